[sv/bmprss_pkg.sv]
package bmprss_pkg;

  localparam int unsigned BufferBytesDef = 64000;
  localparam int unsigned MaxInDimDef    = 4096;

  // quotient bits of the per-pixel scaling divides (one pipeline stage each)
  localparam int unsigned DivSteps = 16;
  // coordinate (13 bit) times output size (16 bit)
  localparam int unsigned ProdW    = 29;
  // width of the shared divider in the configuration unit
  localparam int unsigned DivW     = 32;

  typedef enum logic [2:0] {
    CfgInWidth   = 3'd0,
    CfgInHeight  = 3'd1,
    CfgTopDown   = 3'd2,
    CfgRotateCw  = 3'd3,
    CfgOutWidth  = 3'd4,
    CfgReqHeight = 3'd5,
    CfgMaxHeight = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StWrite  = 2'd0,
    StDrop   = 2'd1,
    StCfgErr = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    DrIdle,
    DrLimLoad,
    DrLimRun,
    DrHgtLoad,
    DrHgtRun,
    DrFinish
  } drv_state_e;

  typedef struct packed {
    logic [11:0] file_row;
    logic [11:0] column;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] byte_address;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [15:0] effective_height;
  } out_t;

  typedef struct packed {
    logic [12:0] in_width;
    logic [12:0] in_height;
    logic        top_down;
    logic        rotate_cw;
    logic [15:0] out_width;
    logic [15:0] height;
    logic [17:0] row_bytes;
    logic        cfg_err;
    logic        busy;
  } cfg_t;

endpackage

[sv/bmp_rotate_scale_scatter_unit.sv]
// Stages, input to output: entry, multiply, 16 divide stages, address multiply,
// output register; one beat per cycle without an output stall or derive pass.
// The two scaling divides run as a 16-stage pipeline, one quotient bit a stage.
// A register write starts a derive pass in a shared serial divider; in_ready_o
// is low during it. Reset loads the default registers and their derived height
// 1, row pitch 4 bytes and no error, with the pipeline empty.
module bmp_rotate_scale_scatter_unit #(
  parameter int unsigned BUFFER_BYTES = bmprss_pkg::BufferBytesDef,
  parameter int unsigned MAX_IN_DIM   = bmprss_pkg::MaxInDimDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmprss_pkg::in_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bmprss_pkg::out_t  out_o
);
  import bmprss_pkg::*;

  cfg_t cfg;

  bmprss_cfg #(
    .BufferBytes (BUFFER_BYTES),
    .MaxInDim    (MAX_IN_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic        en, acc;
  logic [12:0] vw, vh, y, rx, ry;
  logic        oob;
  status_e     st_in;

  logic        s1_v_q;
  status_e     s1_st_q;
  logic [23:0] s1_rgb_q;
  logic [12:0] s1_rx_q, s1_ry_q;

  logic        dv_v_q   [DivSteps+1];
  status_e     dv_st_q  [DivSteps+1];
  logic [23:0] dv_rgb_q [DivSteps+1];
  logic [ProdW-1:0] dv_rx_q [DivSteps+1];
  logic [ProdW-1:0] dv_ry_q [DivSteps+1];
  logic [15:0] dv_qx_q  [DivSteps+1];
  logic [15:0] dv_qy_q  [DivSteps+1];

  logic [ProdW-1:0] nrx [DivSteps];
  logic [ProdW-1:0] nry [DivSteps];
  logic [15:0] nqx [DivSteps];
  logic [15:0] nqy [DivSteps];

  logic        m_v_q;
  status_e     m_st_q;
  logic [23:0] m_rgb_q;
  logic [15:0] m_prod_q, m_ox3_q;
  logic [15:0] rowi;

  logic        out_v_q;
  out_t        out_q;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en && !cfg.busy;
  assign acc        = in_valid_i && in_ready_o;

  assign vw = cfg.rotate_cw ? cfg.in_height : cfg.in_width;
  assign vh = cfg.rotate_cw ? cfg.in_width : cfg.in_height;

  always_comb begin
    oob = ({1'b0, in_i.file_row} >= cfg.in_height) || ({1'b0, in_i.column} >= cfg.in_width);
    y   = cfg.top_down ? {1'b0, in_i.file_row} :
                         13'(cfg.in_height - 13'd1 - {1'b0, in_i.file_row});
    rx  = cfg.rotate_cw ? 13'(cfg.in_height - 13'd1 - y) : {1'b0, in_i.column};
    ry  = cfg.rotate_cw ? {1'b0, in_i.column} : y;
    if (cfg.cfg_err) begin
      st_in = StCfgErr;
    end else if (oob) begin
      st_in = StDrop;
    end else begin
      st_in = StWrite;
    end
  end

  // long division: quotient is below the output size, so 16 bits suffice
  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      nrx[k] = dv_rx_q[k];
      nry[k] = dv_ry_q[k];
      nqx[k] = dv_qx_q[k];
      nqy[k] = dv_qy_q[k];
      if (dv_rx_q[k] >= (ProdW'(vw) << (DivSteps - 1 - k))) begin
        nrx[k] = dv_rx_q[k] - (ProdW'(vw) << (DivSteps - 1 - k));
        nqx[k][DivSteps-1-k] = 1'b1;
      end
      if (dv_ry_q[k] >= (ProdW'(vh) << (DivSteps - 1 - k))) begin
        nry[k] = dv_ry_q[k] - (ProdW'(vh) << (DivSteps - 1 - k));
        nqy[k][DivSteps-1-k] = 1'b1;
      end
    end
  end

  assign rowi = cfg.height - 16'd1 - dv_qy_q[DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      m_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) begin
        dv_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      s1_v_q    <= acc;
      dv_v_q[0] <= s1_v_q;
      for (int k = 0; k < DivSteps; k++) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
      m_v_q   <= dv_v_q[DivSteps];
      out_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_st_q  <= st_in;
      s1_rgb_q <= {in_i.blue, in_i.green, in_i.red};
      s1_rx_q  <= rx;
      s1_ry_q  <= ry;

      dv_st_q[0]  <= s1_st_q;
      dv_rgb_q[0] <= s1_rgb_q;
      dv_rx_q[0]  <= ProdW'(s1_rx_q * cfg.out_width);
      dv_ry_q[0]  <= ProdW'(s1_ry_q * cfg.height);
      dv_qx_q[0]  <= '0;
      dv_qy_q[0]  <= '0;
      for (int k = 0; k < DivSteps; k++) begin
        dv_st_q[k+1]  <= dv_st_q[k];
        dv_rgb_q[k+1] <= dv_rgb_q[k];
        dv_rx_q[k+1]  <= nrx[k];
        dv_ry_q[k+1]  <= nry[k];
        dv_qx_q[k+1]  <= nqx[k];
        dv_qy_q[k+1]  <= nqy[k];
      end

      m_st_q   <= dv_st_q[DivSteps];
      m_rgb_q  <= dv_rgb_q[DivSteps];
      m_prod_q <= 16'(rowi * cfg.row_bytes[15:0]);
      m_ox3_q  <= 16'(dv_qx_q[DivSteps] * 16'd3);

      out_q.status           <= m_st_q;
      out_q.effective_height <= cfg.height;
      if (m_st_q == StWrite) begin
        out_q.byte_address <= m_prod_q + m_ox3_q;
        out_q.out_blue     <= m_rgb_q[23:16];
        out_q.out_green    <= m_rgb_q[15:8];
        out_q.out_red      <= m_rgb_q[7:0];
      end else begin
        out_q.byte_address <= '0;
        out_q.out_blue     <= '0;
        out_q.out_green    <= '0;
        out_q.out_red      <= '0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.status != StWrite |->
      out_q.byte_address == '0 && out_q.out_blue == '0 &&
      out_q.out_green == '0 && out_q.out_red == '0)
    else $error("dropped beat carries payload");

  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.busy |-> !in_ready_o)
    else $error("beat taken during derive pass");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_v_q)
    else $error("accepted beat lost at entry");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(m_v_q) && $stable(s1_v_q))
    else $error("pipeline moved under stall");

endmodule

[sv/bmprss_cfg.sv]
module bmprss_cfg #(
  parameter int unsigned BufferBytes = bmprss_pkg::BufferBytesDef,
  parameter int unsigned MaxInDim    = bmprss_pkg::MaxInDimDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output bmprss_pkg::cfg_t   cfg_o
);
  import bmprss_pkg::*;

  logic [12:0] in_width_q, in_height_q;
  logic        top_down_q, rotate_cw_q;
  logic [15:0] out_width_q, req_height_q, max_height_q;
  logic [15:0] height_q, limit_q;
  logic        err_q;

  drv_state_e  state_q, state_d;
  logic [DivW-1:0] dvd_q, rem_q, dvs_q;
  logic [4:0]  cnt_q;

  logic        start;
  logic        ld_lim, ld_hgt, step, fin, busy;
  logic [17:0] row_bytes;
  logic [12:0] vw, vh;
  logic        src_bad;
  logic [29:0] nw;
  logic [DivW-1:0] num;
  logic [DivW:0]   rem_sh;
  logic        ge;
  logic [15:0] lim_new;
  logic [DivW-1:0] h_raw, h_one;
  logic [15:0] h_fin;
  logic [33:0] size;

  // register file
  always_comb begin
    start = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgInWidth, CfgInHeight, CfgTopDown, CfgRotateCw,
        CfgOutWidth, CfgReqHeight, CfgMaxHeight: start = 1'b1;
        default: start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q   <= 13'd1;
      in_height_q  <= 13'd1;
      top_down_q   <= 1'b0;
      rotate_cw_q  <= 1'b0;
      out_width_q  <= 16'd1;
      req_height_q <= 16'd0;
      max_height_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgInWidth:   in_width_q   <= cfg_data_i[12:0];
        CfgInHeight:  in_height_q  <= cfg_data_i[12:0];
        CfgTopDown:   top_down_q   <= cfg_data_i[0];
        CfgRotateCw:  rotate_cw_q  <= cfg_data_i[0];
        CfgOutWidth:  out_width_q  <= cfg_data_i;
        CfgReqHeight: req_height_q <= cfg_data_i;
        CfgMaxHeight: max_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign row_bytes = (18'({2'b00, out_width_q} * 18'd3) + 18'd3) & ~18'd3;
  assign vw        = rotate_cw_q ? in_height_q : in_width_q;
  assign vh        = rotate_cw_q ? in_width_q : in_height_q;
  assign src_bad   = (in_width_q == '0) || (in_height_q == '0) ||
                     (32'(in_width_q) > MaxInDim) || (32'(in_height_q) > MaxInDim);
  assign nw        = {13'b0, out_width_q, 1'b0} * {17'b0, vw};
  assign num       = {2'b00, nw} + DivW'(vh);

  // restoring divider, one quotient bit per cycle, quotient shifts into dvd_q
  assign rem_sh = {rem_q, dvd_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  assign lim_new = ((row_bytes == '0) || ({16'b0, max_height_q} < dvd_q)) ?
                   max_height_q : dvd_q[15:0];

  always_comb begin
    if (req_height_q != '0) begin
      h_raw = DivW'(req_height_q);
    end else if (vh == '0) begin
      h_raw = '0;
    end else begin
      h_raw = dvd_q;
    end
    h_one = (h_raw == '0) ? DivW'(1) : h_raw;
    h_fin = (h_one > DivW'(limit_q)) ? limit_q : h_one[15:0];
    size  = 34'(row_bytes * h_fin);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DrIdle:    state_d = DrIdle;
      DrLimLoad: state_d = DrLimRun;
      DrLimRun:  state_d = (cnt_q == '1) ? DrHgtLoad : DrLimRun;
      DrHgtLoad: state_d = DrHgtRun;
      DrHgtRun:  state_d = (cnt_q == '1) ? DrFinish : DrHgtRun;
      DrFinish:  state_d = DrIdle;
      default:   state_d = DrIdle;
    endcase
    if (start) begin
      state_d = DrLimLoad;
    end
  end

  // outputs
  always_comb begin
    ld_lim = 1'b0;
    ld_hgt = 1'b0;
    step   = 1'b0;
    fin    = 1'b0;
    busy   = 1'b1;
    unique case (state_q)
      DrIdle:    busy   = 1'b0;
      DrLimLoad: ld_lim = 1'b1;
      DrLimRun:  step   = 1'b1;
      DrHgtLoad: ld_hgt = 1'b1;
      DrHgtRun:  step   = 1'b1;
      DrFinish:  fin    = 1'b1;
      default:   busy   = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= DrIdle;
      height_q <= 16'd1;
      err_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin && !start) begin
        height_q <= h_fin;
        err_q    <= src_bad || (size == '0) || (size > 34'(BufferBytes));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_lim) begin
      dvd_q <= DivW'(BufferBytes);
      dvs_q <= DivW'(row_bytes);
      rem_q <= '0;
      cnt_q <= '0;
    end else if (ld_hgt) begin
      limit_q <= lim_new;
      dvd_q   <= num;
      dvs_q   <= DivW'({vh, 1'b0});
      rem_q   <= '0;
      cnt_q   <= '0;
    end else if (step) begin
      rem_q <= ge ? DivW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DivW-1:0];
      dvd_q <= {dvd_q[DivW-2:0], ge};
      cnt_q <= cnt_q + 5'd1;
    end
  end

  always_comb begin
    cfg_o.in_width  = in_width_q;
    cfg_o.in_height = in_height_q;
    cfg_o.top_down  = top_down_q;
    cfg_o.rotate_cw = rotate_cw_q;
    cfg_o.out_width = out_width_q;
    cfg_o.height    = height_q;
    cfg_o.row_bytes = row_bytes;
    cfg_o.cfg_err   = err_q;
    cfg_o.busy      = busy;
  end

endmodule

[test/bmp_rotate_scale_scatter_unit_test.sv]
`timescale 1ns / 100ps

module bmp_rotate_scale_scatter_unit_test;
  import bmprss_pkg::*;

  localparam int unsigned BufBytes = 64000;
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned Latency  = 20;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [15:0] val;
    in_t         px;
    bit          typed;
    out_t        res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready_o;
  in_t         in_data;
  logic        out_valid_o;
  logic        out_ready;
  out_t        out_o;

  bmp_rotate_scale_scatter_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_i       (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_o      (out_o)
  );

  // shadow of the register file and what the block derives from it
  logic [12:0] sh_in_w, sh_in_h;
  logic        sh_top_down, sh_rot;
  logic [15:0] sh_out_w, sh_req_h, sh_max_h;
  logic [15:0] sh_height;
  logic [17:0] sh_row_bytes;
  logic        sh_err;

  out_t        pending_px[$];
  dir_row_t    dir_rows[$];
  int unsigned in_idle_pct, out_stall_pct;
  int unsigned n_px, n_write, n_drop, n_cfg_err, n_regs, n_fail;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void derive_geometry();
    longint unsigned vw, vh, lim, h, num, sz;
    sh_row_bytes = (18'(sh_out_w) * 18'd3 + 18'd3) & ~18'd3;
    sh_err = (sh_in_w == 0) || (sh_in_h == 0) || (sh_in_w > MaxDim) || (sh_in_h > MaxDim);
    lim = sh_max_h;
    if (sh_row_bytes != 0 && BufBytes / sh_row_bytes < lim) lim = BufBytes / sh_row_bytes;
    vw = sh_rot ? sh_in_h : sh_in_w;
    vh = sh_rot ? sh_in_w : sh_in_h;
    if (sh_req_h != 0) h = sh_req_h;
    else if (vh != 0) begin
      num = 2 * longint'(sh_out_w) * vw + vh;
      h = num / (2 * vh);
    end else h = 0;
    if (h == 0) h = 1;
    if (h > lim) h = lim;
    sh_height = h[15:0];
    sz = longint'(sh_row_bytes) * sh_height;
    if (sz == 0 || sz > BufBytes) sh_err = 1'b1;
  endfunction

  function automatic void shadow_write(cfg_idx_e idx, logic [15:0] v);
    case (idx)
      CfgInWidth:   sh_in_w = v[12:0];
      CfgInHeight:  sh_in_h = v[12:0];
      CfgTopDown:   sh_top_down = v[0];
      CfgRotateCw:  sh_rot = v[0];
      CfgOutWidth:  sh_out_w = v;
      CfgReqHeight: sh_req_h = v;
      CfgMaxHeight: sh_max_h = v;
      default: ;
    endcase
    derive_geometry();
  endfunction

  function automatic out_t scatter_pixel(in_t p);
    out_t r;
    int unsigned y, rx, ry, vw, vh, ox, oy, addr;
    r = '{StDrop, 16'd0, 8'd0, 8'd0, 8'd0, sh_height};
    if (sh_err) begin
      r.status = StCfgErr;
      return r;
    end
    if (p.file_row >= sh_in_h || p.column >= sh_in_w) return r;
    y  = sh_top_down ? p.file_row : sh_in_h - 1 - p.file_row;
    rx = sh_rot ? sh_in_h - 1 - y : p.column;
    ry = sh_rot ? p.column : y;
    vw = sh_rot ? sh_in_h : sh_in_w;
    vh = sh_rot ? sh_in_w : sh_in_h;
    ox = (longint'(rx) * sh_out_w) / vw;
    oy = (longint'(ry) * sh_height) / vh;
    if (ox >= sh_out_w || oy >= sh_height) return r;
    addr = (sh_height - 1 - oy) * sh_row_bytes + ox * 3;
    r.status       = StWrite;
    r.byte_address = addr[15:0];
    r.out_blue     = p.blue;
    r.out_green    = p.green;
    r.out_red      = p.red;
    return r;
  endfunction

  function automatic dir_row_t row_px(logic [11:0] r, logic [11:0] c, logic [7:0] b,
                                      logic [7:0] g, logic [7:0] rd);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.idx    = CfgInWidth;
    d.val    = '0;
    d.px     = '{r, c, b, g, rd};
    d.typed  = 1'b0;
    d.res    = '0;
    return d;
  endfunction

  function automatic dir_row_t row_chk(logic [11:0] r, logic [11:0] c, logic [7:0] b,
                                       logic [7:0] g, logic [7:0] rd, out_t res);
    dir_row_t d;
    d       = row_px(r, c, b, g, rd);
    d.typed = 1'b1;
    d.res   = res;
    return d;
  endfunction

  function automatic dir_row_t row_cfg(cfg_idx_e idx, logic [15:0] v);
    dir_row_t d;
    d        = row_px(0, 0, 0, 0, 0);
    d.is_cfg = 1'b1;
    d.idx    = idx;
    d.val    = v;
    return d;
  endfunction

  // enters and leaves at a falling edge; valid stays up between back-to-back beats
  task automatic send_pixel(in_t p, bit typed, out_t res);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pending_px.insert(pending_px.size(), typed ? res : scatter_pixel(p));
    n_px++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    shadow_write(idx, v);
    n_regs++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    // derive pass holds in_ready low
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_dim();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 88) return 16'($urandom_range(1, 64));
    if (k < 95) return 16'($urandom_range(1, MaxDim));
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'(MaxDim);
      2: return 16'(MaxDim + 1);
      default: return 16'h1fff;
    endcase
  endfunction

  task automatic random_config();
    int unsigned k;
    logic [15:0] ow, rh, mh;
    k = $urandom_range(99);
    if (k < 80) ow = 16'($urandom_range(1, 160));
    else if (k < 92) ow = 16'($urandom_range(1, 21333));
    else ow = ($urandom_range(2) == 0) ? 16'd0 : ($urandom_range(1) ? 16'd21334 : 16'hffff);
    k = $urandom_range(99);
    rh = (k < 50) ? 16'd0 : (k < 95) ? 16'($urandom_range(1, 400)) : 16'hffff;
    mh = ($urandom_range(99) < 70) ? 16'hffff : 16'($urandom);
    drain_results();
    write_reg(CfgInWidth, rand_dim());
    write_reg(CfgInHeight, rand_dim());
    write_reg(CfgTopDown, 16'($urandom_range(1)));
    write_reg(CfgRotateCw, 16'($urandom_range(1)));
    write_reg(CfgOutWidth, ow);
    write_reg(CfgReqHeight, rh);
    write_reg(CfgMaxHeight, mh);
  endtask

  function automatic in_t rand_pixel();
    in_t p;
    p = in_t'({$urandom, $urandom});
    if ($urandom_range(99) < 85) begin
      if (sh_in_h >= 1 && sh_in_h <= MaxDim) p.file_row = 12'($urandom_range(0, sh_in_h - 1));
      if (sh_in_w >= 1 && sh_in_w <= MaxDim) p.column = 12'($urandom_range(0, sh_in_w - 1));
    end
    return p;
  endfunction

  task automatic check_beat(out_t exp_r, out_t got);
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      n_fail++;
    end
    if (got.byte_address !== exp_r.byte_address) begin
      $error("byte_address: expected %0d, got %0d", exp_r.byte_address, got.byte_address);
      n_fail++;
    end
    if (got.out_blue !== exp_r.out_blue) begin
      $error("out_blue: expected %0h, got %0h", exp_r.out_blue, got.out_blue);
      n_fail++;
    end
    if (got.out_green !== exp_r.out_green) begin
      $error("out_green: expected %0h, got %0h", exp_r.out_green, got.out_green);
      n_fail++;
    end
    if (got.out_red !== exp_r.out_red) begin
      $error("out_red: expected %0h, got %0h", exp_r.out_red, got.out_red);
      n_fail++;
    end
    if (got.effective_height !== exp_r.effective_height) begin
      $error("effective_height: expected %0d, got %0d", exp_r.effective_height,
             got.effective_height);
      n_fail++;
    end
  endtask

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_px.size() == 0) begin
        $error("output beat with nothing expected");
        n_fail++;
      end else begin
        check_beat(pending_px.pop_front(), out_o);
        case (out_o.status)
          StWrite: n_write++;
          StDrop:  n_drop++;
          default: n_cfg_err++;
        endcase
      end
    end
  end

  initial begin
    int unsigned phase, i;
    out_t none;
    none = '0;
    n_px = 0; n_write = 0; n_drop = 0; n_cfg_err = 0; n_regs = 0; n_fail = 0;
    in_idle_pct = 20;
    out_stall_pct = 65;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgInWidth;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    sh_in_w = 13'd1; sh_in_h = 13'd1; sh_top_down = 1'b0; sh_rot = 1'b0;
    sh_out_w = 16'd1; sh_req_h = 16'd0; sh_max_h = 16'hffff;
    derive_geometry();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    dir_rows = '{
      row_chk(0, 0, 8'h00, 8'h00, 8'h00, '{StWrite, 16'd0, 8'h00, 8'h00, 8'h00, 16'd1}),
      row_chk(0, 0, 8'hff, 8'hff, 8'hff, '{StWrite, 16'd0, 8'hff, 8'hff, 8'hff, 16'd1}),
      row_chk(1, 0, 8'h12, 8'h34, 8'h56, '{StDrop, 16'd0, 8'h00, 8'h00, 8'h00, 16'd1}),
      row_chk(0, 1, 8'h12, 8'h34, 8'h56, '{StDrop, 16'd0, 8'h00, 8'h00, 8'h00, 16'd1}),
      row_chk(12'hfff, 12'hfff, 8'ha5, 8'h5a, 8'hc3,
              '{StDrop, 16'd0, 8'h00, 8'h00, 8'h00, 16'd1}),
      row_cfg(CfgInWidth, 16'd0),
      row_chk(0, 0, 8'h11, 8'h22, 8'h33, '{StCfgErr, 16'd0, 8'h00, 8'h00, 8'h00, 16'd1}),
      row_cfg(CfgInWidth, 16'd4096),
      row_cfg(CfgInHeight, 16'd4096),
      row_cfg(CfgOutWidth, 16'd100),
      row_px(0, 0, 8'h01, 8'h02, 8'h03),
      row_px(12'hfff, 12'hfff, 8'hff, 8'h00, 8'hff),
      row_px(12'hfff, 0, 8'h80, 8'h40, 8'h20),
      row_px(0, 12'hfff, 8'h7f, 8'hfe, 8'h01),
      row_cfg(CfgTopDown, 16'd1),
      row_px(0, 0, 8'h10, 8'h20, 8'h30),
      row_px(12'hfff, 12'hfff, 8'h44, 8'h55, 8'h66),
      row_cfg(CfgRotateCw, 16'd1),
      row_px(0, 12'hfff, 8'h99, 8'h88, 8'h77),
      row_px(12'hfff, 0, 8'h01, 8'h10, 8'h11),
      row_cfg(CfgReqHeight, 16'd500),
      row_px(12'h800, 12'd123, 8'hde, 8'had, 8'hbe),
      row_cfg(CfgMaxHeight, 16'd0),
      row_chk(0, 0, 8'h11, 8'h22, 8'h33, '{StCfgErr, 16'd0, 8'h00, 8'h00, 8'h00, 16'd0}),
      row_cfg(CfgMaxHeight, 16'hffff),
      // zero row pitch
      row_cfg(CfgOutWidth, 16'd0),
      row_chk(0, 0, 8'h11, 8'h22, 8'h33, '{StCfgErr, 16'd0, 8'h00, 8'h00, 8'h00, 16'd500}),
      // one row already larger than the buffer
      row_cfg(CfgOutWidth, 16'hffff),
      row_chk(0, 0, 8'h11, 8'h22, 8'h33, '{StCfgErr, 16'd0, 8'h00, 8'h00, 8'h00, 16'd0}),
      row_cfg(CfgOutWidth, 16'd21333),
      row_px(0, 0, 8'hab, 8'hcd, 8'hef),
      row_px(12'hfff, 12'hfff, 8'h12, 8'h34, 8'h56),
      row_cfg(CfgInHeight, 16'h1fff),
      row_chk(0, 0, 8'h11, 8'h22, 8'h33, '{StCfgErr, 16'd0, 8'h00, 8'h00, 8'h00, 16'd1}),
      row_cfg(CfgInHeight, 16'd3),
      row_cfg(CfgInWidth, 16'd5),
      row_cfg(CfgReqHeight, 16'd0),
      row_cfg(CfgOutWidth, 16'd7),
      row_cfg(CfgRotateCw, 16'd0),
      row_cfg(CfgTopDown, 16'd0),
      row_px(0, 0, 8'h01, 8'h02, 8'h03),
      row_px(2, 4, 8'h04, 8'h05, 8'h06),
      row_px(1, 2, 8'h07, 8'h08, 8'h09),
      row_px(3, 4, 8'h0a, 8'h0b, 8'h0c)
    };
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        drain_results();
        write_reg(dir_rows[k].idx, dir_rows[k].val);
      end else begin
        send_pixel(dir_rows[k].px, dir_rows[k].typed, dir_rows[k].res);
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      in_idle_pct   = (phase == 0) ? 20 : (phase == 1) ? 65 : 0;
      out_stall_pct = (phase == 0) ? 65 : (phase == 1) ? 20 : 0;
      for (i = 0; i < 440; i++) begin
        if (i % 55 == 0) random_config();
        send_pixel(rand_pixel(), 1'b0, none);
      end
    end

    drain_results();
    repeat (Latency) @(posedge clk_i);
    $display("Covered %0d pixel beats over %0d register writes", n_px, n_regs);
    $display("Results: %0d written, %0d dropped, %0d with invalid setup",
             n_write, n_drop, n_cfg_err);
    if (n_fail == 0 && pending_px.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
sv/bmprss_pkg.sv
sv/bmprss_cfg.sv
sv/bmp_rotate_scale_scatter_unit.sv
test/bmp_rotate_scale_scatter_unit_test.sv
